// ===== rtl/lbp_pkg.sv =====
// Shared constants and types for the 3x3 local binary pattern stream unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lbp_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIXEL_W     = 8;
   localparam int CODE_W      = 8;
   localparam int ROW_W       = 12;
   localparam int COL_W       = 11;
   localparam int FW_W        = 12;
   localparam int FH_W        = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam int              MIN_SIZE           = 3;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   // Position of the center pixel that a request produces, and whether it does.
   typedef struct packed {
      logic             emit;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } pos_type;

endpackage

`default_nettype wire

// ===== rtl/lbp_req_if.sv =====
// Request channel: one grayscale pixel per transfer with a frame start flag.
// Depends on lbp_pkg for field widths.
`default_nettype none

interface lbp_req_if;
   import lbp_pkg::*;

   logic            valid;
   logic            ready;
   logic [PIXEL_W-1:0] pixel;
   logic            frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/lbp_rsp_if.sv =====
// Response channel: one LBP code with the position of its centre pixel.
// Depends on lbp_pkg for field widths.
`default_nettype none

interface lbp_rsp_if;
   import lbp_pkg::*;

   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  code;
   logic [ROW_W-1:0]   row;
   logic [COL_W-1:0]   col;
   logic               frame_last;

   modport source (output valid, output code, output row, output col, output frame_last,
                   input ready);
   modport sink   (input valid, input code, input row, input col, input frame_last,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/lbp_ctrl.sv =====
// Frame size registers and raster position counters.
// Depends on lbp_pkg; produces the line buffer address and center position.
`default_nettype none

module lbp_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_write_en,
   input  wire [lbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [lbp_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire                           accept,
   input  wire                           frame_start,
   output lbp_pkg::addr_type             addr,
   output lbp_pkg::pos_type              pos
);
   import lbp_pkg::*;

   logic [FW_W-1:0]  frame_width_ff,  frame_width_in;
   logic [FH_W-1:0]  frame_height_ff, frame_height_in;
   logic [ROW_W-1:0] row_count_ff,    row_count_in;
   logic [COL_W-1:0] col_count_ff,    col_count_in;

   logic [FW_W-1:0]  w_eff;
   logic [FH_W-1:0]  h_eff;
   logic [ROW_W-1:0] r;
   logic [COL_W-1:0] c;
   logic [FW_W-1:0]  col_next;
   logic [FH_W-1:0]  row_next;
   logic             col_end;
   logic             row_end;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_data[FH_W-1:0];
            default: begin
               frame_width_in  = frame_width_ff;
               frame_height_in = frame_height_ff;
            end
         endcase
      end
   end

   // Out-of-range sizes are pinned to the supported range.
   always_comb begin
      if (frame_width_ff < FW_W'(MIN_SIZE)) begin
         w_eff = FW_W'(MIN_SIZE);
      end else if (frame_width_ff > FW_W'(MAX_WIDTH)) begin
         w_eff = FW_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff < FH_W'(MIN_SIZE)) begin
         h_eff = FH_W'(MIN_SIZE);
      end else if (frame_height_ff > FH_W'(MAX_HEIGHT)) begin
         h_eff = FH_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   always_comb begin
      r        = frame_start ? '0 : row_count_ff;
      c        = frame_start ? '0 : col_count_ff;
      col_next = FW_W'(c) + FW_W'(1);
      row_next = FH_W'(r) + FH_W'(1);
      col_end  = (col_next >= w_eff);
      row_end  = (row_next >= h_eff);

      addr     = c[ADDR_W-1:0];
      pos.emit = (r >= ROW_W'(2)) && (c >= COL_W'(2));
      pos.row  = r - ROW_W'(1);
      pos.col  = c - COL_W'(1);
      pos.last = row_end && col_end;

      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (accept) begin
         if (col_end) begin
            col_count_in = '0;
            row_count_in = row_end ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_count_in = col_next[COL_W-1:0];
            row_count_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         row_count_ff    <= '0;
         col_count_ff    <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         row_count_ff    <= row_count_in;
         col_count_ff    <= col_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lbp_line_buf.sv =====
// Two row buffers holding the previous two image rows, with registered reads.
// Depends on lbp_pkg; fed by lbp_ctrl, read by lbp_window.
`default_nettype none

module lbp_line_buf (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  lbp_pkg::addr_type   addr,
   input  lbp_pkg::pixel_type  pixel,
   output lbp_pkg::pixel_type  top,
   output lbp_pkg::pixel_type  mid
);
   import lbp_pkg::*;

   pixel_type top_mem [MAX_WIDTH];
   pixel_type mid_mem [MAX_WIDTH];

   pixel_type top_q_ff;
   pixel_type mid_q_ff;
   pixel_type fwd_val_ff;
   logic      fwd_ff;
   logic      wr_pend_ff, wr_pend_in;
   addr_type  wr_addr_ff;
   logic      hit;

   // The row above moves up one line in the cycle after its read. A request right
   // behind it at the same column takes that value before it reaches memory.
   assign hit        = wr_pend_ff && (wr_addr_ff == addr);
   assign wr_pend_in = accept;

   always_ff @(posedge clock) begin
      if (accept) begin
         top_q_ff      <= top_mem[addr];
         mid_q_ff      <= mid_mem[addr];
         mid_mem[addr] <= pixel;
         fwd_ff        <= hit;
         fwd_val_ff    <= mid_q_ff;
         wr_addr_ff    <= addr;
      end
      if (wr_pend_ff) begin
         top_mem[wr_addr_ff] <= mid_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= wr_pend_in;
      end
   end

   assign top = fwd_ff ? fwd_val_ff : top_q_ff;
   assign mid = mid_q_ff;

endmodule

`default_nettype wire

// ===== rtl/lbp_window.sv =====
// 3x3 window, pattern compare and the response register.
// Depends on lbp_pkg; takes buffer reads from lbp_line_buf.
`default_nettype none

module lbp_window (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  lbp_pkg::pixel_type  pixel,
   input  lbp_pkg::pos_type    pos,
   input  lbp_pkg::pixel_type  top,
   input  lbp_pkg::pixel_type  mid,
   output logic                in_ready,
   output logic                out_valid,
   input  wire                 out_ready,
   output logic [lbp_pkg::CODE_W-1:0] out_code,
   output logic [lbp_pkg::ROW_W-1:0]  out_row,
   output logic [lbp_pkg::COL_W-1:0]  out_col,
   output logic                       out_last
);
   import lbp_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   pixel_type  px_ff;
   pos_type    pos_ff;

   // Columns: index 0 is the left column, index 1 the middle one.
   pixel_type  win_ff [3][2];
   pixel_type  right [3];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic              last_ff;

   logic       out_free;
   logic       s1_adv;
   pixel_type  ctr;

   assign out_free = !rsp_valid_ff || out_ready;
   assign s1_adv   = s1_valid_ff && (!pos_ff.emit || out_free);
   assign in_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      right[0] = top;
      right[1] = mid;
      right[2] = px_ff;
      ctr      = win_ff[1][1];
      code_in[7] = win_ff[0][0] > ctr;
      code_in[6] = win_ff[0][1] > ctr;
      code_in[5] = right[0]     > ctr;
      code_in[4] = right[1]     > ctr;
      code_in[3] = right[2]     > ctr;
      code_in[2] = win_ff[2][1] > ctr;
      code_in[1] = win_ff[2][0] > ctr;
      code_in[0] = win_ff[1][0] > ctr;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && pos_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff  <= pixel;
         pos_ff <= pos;
      end
      if (s1_adv && pos_ff.emit) begin
         code_ff <= code_in;
         row_ff  <= pos_ff.row;
         col_ff  <= pos_ff.col;
         last_ff <= pos_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= '0;
            win_ff[i][1] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= right[i];
            end
         end
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_code  = code_ff;
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/lbp_3x3_pixel_stream_unit.sv =====
// Top level of the 3x3 local binary pattern unit over a raster pixel stream.
// Depends on lbp_pkg, lbp_req_if, lbp_rsp_if, lbp_ctrl, lbp_line_buf, lbp_window.
`default_nettype none

// The unit takes one 8-bit pixel per clock in raster order and, for every
// pixel at row and column two or more, returns the 8-bit pattern of the pixel
// up and to the left of it (top-left neighbor in bit 7, clockwise, left
// neighbor in bit 0), with that center's row, column and an end-of-frame flag.
// Border pixels give no response. A request is registered together with its
// two row memory reads, and its response is then loaded into the output
// register once that register is free or its response is being taken.
// One request per clock is sustained while responses are taken; a
// response held by back pressure stalls requests only once the registered
// request would produce another response. The two row memories (2048 x 8
// each) are read and written once per cycle, the upper one at two different
// columns. Frame width and height may be written at index 0 and 1 while the
// unit is idle; sizes below 3 or above 2048 columns or 4096 rows are pinned.
// The row memories are not cleared at reset; the first two rows of a frame
// fill them before any response depends on them.
module lbp_3x3_pixel_stream_unit (
   input  wire                            clock,
   input  wire                            reset,
   lbp_req_if.sink                        req_chan,
   lbp_rsp_if.source                      rsp_chan,
   input  wire                            csr_write_en,
   input  wire [lbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [lbp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lbp_pkg::*;

   logic      accept;
   logic      in_ready;
   addr_type  addr;
   pos_type   pos;
   pixel_type top;
   pixel_type mid;

   assign req_chan.ready = in_ready;
   assign accept         = req_chan.valid && in_ready;

   lbp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .frame_start  (req_chan.frame_start),
      .addr         (addr),
      .pos          (pos)
   );

   lbp_line_buf u_line_buf (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .addr   (addr),
      .pixel  (req_chan.pixel),
      .top    (top),
      .mid    (mid)
   );

   lbp_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (req_chan.pixel),
      .pos       (pos),
      .top       (top),
      .mid       (mid),
      .in_ready  (in_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_code  (rsp_chan.code),
      .out_row   (rsp_chan.row),
      .out_col   (rsp_chan.col),
      .out_last  (rsp_chan.frame_last)
   );

endmodule

`default_nettype wire

// ===== rtl/lbp_checker.sv =====
// Port-level checks for the LBP stream unit, bound to its top level.
// Depends on lbp_pkg for field widths and on lbp_3x3_pixel_stream_unit.
`default_nettype none

module lbp_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire [lbp_pkg::CODE_W-1:0]  rsp_code,
   input wire [lbp_pkg::ROW_W-1:0]   rsp_row,
   input wire [lbp_pkg::COL_W-1:0]   rsp_col,
   input wire                        rsp_frame_last
);
   import lbp_pkg::*;

   // A stalled response holds its whole payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) && $stable(rsp_row)
                                  && $stable(rsp_col) && $stable(rsp_frame_last))
      else $error("stalled response changed");

   // Nothing is presented straight out of reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Centers are never on the top row or the left column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row != '0) && (rsp_col != '0))
      else $error("response for a border pixel");

   // Requests back up only behind a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled response");

endmodule

bind lbp_3x3_pixel_stream_unit lbp_checker u_lbp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_code       (rsp_chan.code),
   .rsp_row        (rsp_chan.row),
   .rsp_col        (rsp_chan.col),
   .rsp_frame_last (rsp_chan.frame_last)
);

`default_nettype wire

// ===== test/lbp_stream_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the 3x3 LBP pixel stream unit: tracks register writes, predicts
// one pattern per interior pixel request and compares every response in order.
// Depends on lbp_pkg, lbp_req_if and lbp_rsp_if.

module lbp_stream_checker (
   input  wire                            clock,
   input  wire                            reset,
   lbp_req_if                             req_chan,
   lbp_rsp_if                             rsp_chan,
   input  wire                            csr_write_en,
   input  wire [lbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [lbp_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                             fail_count,
   output int                             pending_count
);
   import lbp_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              frame_last;
   } lbp_result_type;

   logic [FW_W-1:0]  width_reg;
   logic [FH_W-1:0]  height_reg;
   pixel_type        older_line [0:MAX_WIDTH-1];
   pixel_type        newer_line [0:MAX_WIDTH-1];
   pixel_type        win [0:2][0:2];
   logic [ROW_W-1:0] row_pos;
   logic [COL_W-1:0] col_pos;
   lbp_result_type   codes_due [$];

   function automatic int pinned(int v, int hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // Shifts the request into the row buffers and the window, and queues the
   // pattern of the pixel up and to the left once the window is interior.
   task automatic slide_window(input pixel_type px, input logic fs);
      int             w;
      int             h;
      pixel_type      top_px;
      pixel_type      mid_px;
      pixel_type      ctr;
      lbp_result_type res;
      w = pinned(int'(width_reg), MAX_WIDTH);
      h = pinned(int'(height_reg), MAX_HEIGHT);
      if (fs) begin
         row_pos = '0;
         col_pos = '0;
      end
      top_px = older_line[col_pos];
      mid_px = newer_line[col_pos];
      older_line[col_pos] = mid_px;
      newer_line[col_pos] = px;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = top_px;
      win[1][2] = mid_px;
      win[2][2] = px;
      if (row_pos >= 2 && col_pos >= 2) begin
         ctr = win[1][1];
         // Clockwise from the top-left neighbor down to the left one.
         res.code = {win[0][0] > ctr, win[0][1] > ctr, win[0][2] > ctr, win[1][2] > ctr,
                     win[2][2] > ctr, win[2][1] > ctr, win[2][0] > ctr, win[1][0] > ctr};
         res.row = row_pos - 1'b1;
         res.col = col_pos - 1'b1;
         res.frame_last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
         codes_due.push_back(res);
      end
      if (col_pos + 1 >= w) begin
         col_pos = '0;
         if (row_pos + 1 >= h) row_pos = '0;
         else row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   task automatic check_response();
      lbp_result_type want;
      if (codes_due.size() == 0) begin
         report_error($sformatf("response with no request waiting: code %0d row %0d col %0d",
                                rsp_chan.code, rsp_chan.row, rsp_chan.col));
         return;
      end
      want = codes_due.pop_front();
      if (rsp_chan.code !== want.code)
         report_error($sformatf("code got %0h expected %0h (row %0d col %0d)",
                                rsp_chan.code, want.code, want.row, want.col));
      if (rsp_chan.row !== want.row)
         report_error($sformatf("row got %0d expected %0d", rsp_chan.row, want.row));
      if (rsp_chan.col !== want.col)
         report_error($sformatf("col got %0d expected %0d", rsp_chan.col, want.col));
      if (rsp_chan.frame_last !== want.frame_last)
         report_error($sformatf("frame_last got %0b expected %0b (row %0d col %0d)",
                                rsp_chan.frame_last, want.frame_last, want.row, want.col));
   endtask

   always @(posedge clock) begin : observe
      if (reset) begin
         width_reg = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) win[i][j] = '0;
         end
         row_pos = '0;
         col_pos = '0;
         codes_due.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) slide_window(req_chan.pixel, req_chan.frame_start);
         if (rsp_chan.valid && rsp_chan.ready) check_response();
         if (csr_write_en) begin
            if (csr_index == CSR_FRAME_WIDTH) width_reg = csr_data[FW_W-1:0];
            else if (csr_index == CSR_FRAME_HEIGHT) height_reg = csr_data[FH_W-1:0];
         end
      end
      pending_count = codes_due.size();
   end

endmodule

// ===== test/tb_lbp_3x3_pixel_stream_unit.sv =====
`timescale 1ns / 100ps
// Top of the LBP unit testbench: clock, reset, register writes, pixel requests
// and response back pressure, with lbp_stream_checker judging the responses.
// Depends on lbp_pkg, both channel interfaces, the unit and the checker.

module tb_lbp_3x3_pixel_stream_unit;
   import lbp_pkg::*;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     fail_count;
   int                     pending_count;
   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;
   int                     cur_width = 640;
   int                     cur_height = 480;
   int                     pos_row = 0;
   int                     pos_col = 0;
   logic                   restart_needed = 1'b0;
   pixel_type              last_px = '0;

   lbp_req_if req_chan ();
   lbp_rsp_if rsp_chan ();

   lbp_3x3_pixel_stream_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   lbp_stream_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int pinned(int v, int hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Mostly uniform values, with near repeats so that equal neighbors show up.
   function automatic pixel_type random_pixel();
      case ($urandom_range(9))
         6, 7:    return last_px + pixel_type'($urandom_range(4)) - 8'd2;
         8:       return {PIXEL_W{1'($urandom_range(1))}};
         9:       return last_px;
         default: return pixel_type'($urandom_range(255));
      endcase
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 49 : (mode == IDLE_BOTH) ? 8 : 0;
      recv_stall_pct = (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 8 : 0;
   endtask

   // Writes both size registers; the unit must be idle.
   task automatic configure(input logic [CSR_DATA_W-1:0] w_data,
                            input logic [CSR_DATA_W-1:0] h_data);
      int new_w;
      csr_write_en <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data <= w_data;
      @(negedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data <= h_data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      new_w = pinned(int'(w_data[FW_W-1:0]), MAX_WIDTH);
      // A wider row would read buffer columns never written, so it must begin a frame.
      restart_needed = (new_w > cur_width);
      cur_width = new_w;
      cur_height = pinned(int'(h_data[FH_W-1:0]), MAX_HEIGHT);
   endtask

   task automatic send_pixel(input pixel_type px, input logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= px;
      req_chan.frame_start <= fs;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      last_px = px;
      if (fs) begin
         pos_row = 0;
         pos_col = 0;
      end
      if (pos_col + 1 >= cur_width) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= cur_height) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      // A request that gives no response may still be in flight.
      repeat (8) @(negedge clock);
   endtask

   task automatic run_random_phase(input int n_items, input idle_mode_type mode);
      logic fs;
      set_idling(mode);
      for (int k = 0; k < n_items; k++) begin
         if (k == 0) fs = restart_needed || $urandom_range(1);
         else if (pos_row == 0 && pos_col == 0) fs = ($urandom_range(9) < 7);
         else fs = ($urandom_range(99) == 0);
         if (k == n_items / 2 || $urandom_range(149) == 0) drain();
         send_pixel(random_pixel(), fs);
      end
      drain();
   endtask

   initial begin : stimulus
      pixel_type                directed_px [22];
      logic [CSR_DATA_W-1:0] w_data;
      logic [CSR_DATA_W-1:0] h_data;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.pixel = '0;
      req_chan.frame_start = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset sizes: two full rows of 640 and the start of the third.
      set_idling(IDLE_RECEIVER);
      for (int k = 0; k < 2 * 640 + 16; k++) send_pixel(random_pixel(), 1'b0);
      drain();

      // Sizes below the minimum are pinned to 3x3. The first frame mixes equal,
      // smaller and larger neighbors; the second wraps in without a frame start
      // and is cut short by one that arrives mid-frame.
      configure(13'd2, 13'd0);
      set_idling(IDLE_NONE);
      directed_px = '{8'd200, 8'd10, 8'd255, 8'd0, 8'd100, 8'd101, 8'd100, 8'd99, 8'd255,
                      8'd0, 8'd255, 8'd0, 8'd255,
                      8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
      for (int k = 0; k < 22; k++) send_pixel(directed_px[k], k == 0 || k == 13);
      drain();

      // Small random sizes, with widths whose bit 12 the 12-bit register drops
      // and heights above the maximum that are pinned to it.
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(9))
            0:       w_data = 13'($urandom_range(2));
            1:       w_data = 13'h1000 | 13'($urandom_range(3, 12));
            default: w_data = 13'($urandom_range(3, 12));
         endcase
         case ($urandom_range(7))
            0:       h_data = 13'($urandom_range(2));
            1:       h_data = 13'h1FFF;
            default: h_data = 13'($urandom_range(3, 7));
         endcase
         configure(w_data, h_data);
         run_random_phase(66, idle_mode_type'(phase % 4));
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lbp_pkg.sv
rtl/lbp_req_if.sv
rtl/lbp_rsp_if.sv
rtl/lbp_ctrl.sv
rtl/lbp_line_buf.sv
rtl/lbp_window.sv
rtl/lbp_3x3_pixel_stream_unit.sv
rtl/lbp_checker.sv
test/lbp_stream_checker.sv
test/tb_lbp_3x3_pixel_stream_unit.sv
